FILE: rtl/cbke_pkg.sv
// Shared types, constants and reset-value functions for the B-spline knot editor.
package cbke_pkg;

  localparam int NUM_POINTS_DEF = 9;
  localparam int ORDER_DEF      = 4;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int KNOT_W     = 16;
  localparam int COORD_W    = 16;
  localparam int SPACING_W  = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Basis values and coefficients are Q2.16 limited to [-2.0, 2.0].
  localparam int COEF_W   = 19;
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 16;

  localparam logic [2:0] CMD_WRITE_KNOT  = 3'd0;
  localparam logic [2:0] CMD_WRITE_POINT = 3'd1;
  localparam logic [2:0] CMD_NUDGE_UP    = 3'd2;
  localparam logic [2:0] CMD_NUDGE_DOWN  = 3'd3;
  localparam logic [2:0] CMD_EVALUATE    = 3'd4;
  localparam logic [2:0] CMD_RESET_KNOTS = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_KNOT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOT_SPACING = 1'b1;

  typedef struct packed {
    logic [2:0]                command;
    logic [3:0]                knot_index;
    logic [KNOT_W-1:0]         knot_value;
    logic [3:0]                point_index;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [KNOT_W-1:0]         eval_point;
  } cbke_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic                      status;
  } cbke_out_t;

  // Knot ring control: rotate toward the head, rotate back, write.
  typedef struct packed {
    logic fwd;
    logic back;
    logic wr;
  } cbke_kctl_t;

  typedef struct packed {
    logic [KNOT_W-1:0] t0;
    logic [KNOT_W-1:0] t1;
    logic [KNOT_W-1:0] t2;
    logic [KNOT_W-1:0] t3;
    logic [KNOT_W-1:0] t4;
    logic [KNOT_W-1:0] tl;
  } cbke_ktaps_t;

  function automatic logic [SPACING_W-1:0] spacing_reset_val(int frac);
    int v;
    v = 6 << frac;
    if (v > 8191) v = 8191;
    return SPACING_W'(v);
  endfunction

  function automatic logic [KNOT_W-1:0] max_knot_reset_val(int frac);
    int v;
    v = 80 << frac;
    if (v > 65535) v = 65535;
    return KNOT_W'(v);
  endfunction

  function automatic logic [KNOT_W-1:0] knot_reset_val(int i, int frac);
    int v;
    v = i * int'(spacing_reset_val(frac));
    if (v > 65535) v = 65535;
    return KNOT_W'(v);
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    int c;
    c = v;
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    return COORD_W'(c);
  endfunction

  function automatic logic [COORD_W-1:0] px_reset_val(int i, int frac);
    return clamp_coord((10 * i - 40) * (1 << frac));
  endfunction

  function automatic logic [COORD_W-1:0] py_reset_val(int i, int frac);
    return clamp_coord(((i % 2 == 1) ? 30 : -20) * (1 << frac));
  endfunction

endpackage

FILE: rtl/cbke_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module cbke_div #(
  parameter int NUM_W = cbke_pkg::DIV_NUM_W,
  parameter int DEN_W = cbke_pkg::DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);
  localparam int CW = $clog2(NUM_W);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   diff;

  always_comb begin
    rem_sh = {rem, q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den};
    diff   = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= dividend;
        den  <= divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        // The dividend shifts out at the top while quotient bits enter below.
        rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        q   <= {q[NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;

endmodule

FILE: rtl/cbke_kring.sv
// Knot store held as a bidirectional rotating ring with fixed taps at the head.
module cbke_kring #(
  parameter int NK        = cbke_pkg::NUM_POINTS_DEF + cbke_pkg::ORDER_DEF,
  parameter int FRAC_BITS = cbke_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cbke_pkg::cbke_kctl_t          kctl,
  input  logic [cbke_pkg::KNOT_W-1:0]   wdata,
  output cbke_pkg::cbke_ktaps_t         taps
);
  import cbke_pkg::*;

  logic [KNOT_W-1:0] k [NK];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NK; p++) k[p] <= knot_reset_val(p, FRAC_BITS);
    end else if (kctl.fwd) begin
      for (int p = 0; p < NK - 1; p++) k[p] <= k[p+1];
      // A write during a forward rotation replaces the knot leaving the head.
      k[NK-1] <= kctl.wr ? wdata : k[0];
    end else if (kctl.back) begin
      k[0] <= k[NK-1];
      for (int p = 1; p < NK; p++) k[p] <= k[p-1];
    end else if (kctl.wr) begin
      k[0] <= wdata;
    end
  end

  assign taps.t0 = k[0];
  assign taps.t1 = k[1];
  assign taps.t2 = k[2];
  assign taps.t3 = k[3];
  assign taps.t4 = k[4];
  assign taps.tl = k[NK-1];

endmodule

FILE: rtl/cubic_bspline_knot_editor_evaluator_unit.sv
// Cubic B-spline knot editor and evaluator top level with its command sequencer.
// One command is taken at a time and gives one result. Knots, control points and
// basis values sit in rotating rings that step one entry per cycle while enabled.
// Writing a knot turns the knot ring to the addressed knot and on round to its
// start. A nudge that pushes knots along reaches the index, scans for the first
// free neighbour and steps back over the pushed ones. Writing a point passes once
// round the NUM_POINTS control points and reloading uniform knots once round the
// NUM_POINTS+ORDER knots. An evaluation runs the Cox-de Boor recursion over every
// basis term and then the weighted sum; the bit-serial divider, which produces
// both span coefficients of every term with a nonzero span one quotient bit per
// cycle, dominates its run time. A finished result waits in the output register
// while the next request is taken.
module cubic_bspline_knot_editor_evaluator_unit #(
  parameter int NUM_POINTS = cbke_pkg::NUM_POINTS_DEF,
  parameter int ORDER      = cbke_pkg::ORDER_DEF,
  parameter int FRAC_BITS  = cbke_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cbke_pkg::cbke_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cbke_pkg::cbke_out_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cbke_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbke_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cbke_pkg::*;

  localparam int NK    = NUM_POINTS + ORDER;
  localparam int NB    = NK - 1;
  localparam int NP    = NUM_POINTS;
  localparam int HD_W  = $clog2(NK);
  localparam int CNT_W = $clog2(NK + 1);
  localparam int RACC_W = $clog2(NK * 8191 + 1);
  localparam int SUM_W = COEF_W + COORD_W + $clog2(NUM_POINTS) + 1;
  localparam int PROD_W = 2 * COEF_W;
  localparam int LVL_W  = PROD_W + 1;
  localparam logic [KNOT_W:0] ONE_U = (KNOT_W + 1)'(1) << FRAC_BITS;
  localparam logic signed [COEF_W-1:0] Q_ONE = COEF_W'(65536);
  localparam logic signed [COEF_W-1:0] Q_LIM = COEF_W'(131072);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEEK, ST_KWR, ST_ALIGN, ST_PWR, ST_RSTK,
    ST_NUP_SCAN, ST_NUP_SET, ST_NUP_BACK, ST_NUP_STEP,
    ST_NDN_SCAN, ST_NDN_SET, ST_NDN_FWD, ST_NDN_STEP,
    ST_EV_L1, ST_EV_C1, ST_EV_D1, ST_EV_C2, ST_EV_D2,
    ST_EV_M1, ST_EV_M2, ST_EV_M3, ST_EV_NBROT, ST_EV_KAL,
    ST_EV_S1, ST_EV_S2, ST_EV_FIN, ST_DONE
  } state_t;

  state_t state;
  cbke_in_t req;
  logic [HD_W-1:0]  hd;
  logic [CNT_W-1:0] cnt;
  logic [2:0]       lvl;
  logic             sat;
  logic             neg;
  logic [KNOT_W-1:0]    max_knot;
  logic [SPACING_W-1:0] knot_spacing;
  logic [RACC_W-1:0]    racc;
  logic signed [COEF_W-1:0] c1, c2;
  logic signed [PROD_W-1:0] prod, acc;
  logic signed [COEF_W+COORD_W-1:0] xprod, yprod;
  logic signed [SUM_W-1:0] sx, sy;
  logic signed [COORD_W-1:0] res_x, res_y;

  logic signed [COEF_W-1:0]  nb [NB];
  logic signed [COORD_W-1:0] px [NP];
  logic signed [COORD_W-1:0] py [NP];

  cbke_kctl_t        kctl;
  logic [KNOT_W-1:0] kwdata;
  cbke_ktaps_t       kt;

  cbke_kring #(.NK(NK), .FRAC_BITS(FRAC_BITS)) u_kring (
    .clk(clk), .rst(rst), .kctl(kctl), .wdata(kwdata), .taps(kt)
  );

  // Divider operands for the two span coefficients of one basis term.
  logic [KNOT_W-1:0]        tb, td;
  logic [KNOT_W-1:0]        u;
  logic signed [KNOT_W:0]   num_s, den_s;
  logic [KNOT_W-1:0]        num_mag, den_mag;
  logic                     span_zero, span_hit, div_start, div_done;
  logic [DIV_NUM_W-1:0]     div_q;
  logic                     coef_sat;
  logic signed [COEF_W-1:0] coef_q;

  assign u = req.eval_point;

  always_comb begin
    case (lvl)
      3'd2:    begin tb = kt.t1; td = kt.t2; end
      3'd3:    begin tb = kt.t2; td = kt.t3; end
      default: begin tb = kt.t3; td = kt.t4; end
    endcase
    if (state == ST_EV_C2) begin
      num_s    = $signed({1'b0, td}) - $signed({1'b0, u});
      den_s    = $signed({1'b0, td}) - $signed({1'b0, kt.t1});
      span_hit = (u == td);
    end else begin
      num_s    = $signed({1'b0, u}) - $signed({1'b0, kt.t0});
      den_s    = $signed({1'b0, tb}) - $signed({1'b0, kt.t0});
      span_hit = (u == kt.t0);
    end
    span_zero = (den_s == '0);
    num_mag   = num_s[KNOT_W] ? KNOT_W'(-num_s) : num_s[KNOT_W-1:0];
    den_mag   = den_s[KNOT_W] ? KNOT_W'(-den_s) : den_s[KNOT_W-1:0];
    div_start = (state == ST_EV_C1 || state == ST_EV_C2) && !span_zero;
  end

  cbke_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({num_mag, 16'b0}), .divisor(den_mag),
    .done(div_done), .quotient(div_q)
  );

  always_comb begin
    coef_sat = div_q > DIV_NUM_W'(131072);
    if (coef_sat) coef_q = neg ? -Q_LIM : Q_LIM;
    else if (neg) coef_q = -$signed({1'b0, div_q[COEF_W-2:0]});
    else          coef_q = $signed({1'b0, div_q[COEF_W-2:0]});
  end

  // Level combination, truncated toward zero and limited to [-2.0, 2.0].
  logic signed [LVL_W-1:0]     lvl_sum, lvl_adj;
  logic signed [LVL_W-17:0]    lvl_q;
  logic signed [COEF_W-1:0]    lvl_val;
  logic                        lvl_sat;

  always_comb begin
    lvl_sum = acc + prod;
    lvl_adj = lvl_sum[LVL_W-1] ? lvl_sum + LVL_W'(65535) : lvl_sum;
    lvl_q   = lvl_adj[LVL_W-1:16];
    lvl_sat = 1'b1;
    if (lvl_q > (LVL_W-16)'(131072))       lvl_val = Q_LIM;
    else if (lvl_q < -(LVL_W-16)'(131072)) lvl_val = -Q_LIM;
    else begin
      lvl_val = lvl_q[COEF_W-1:0];
      lvl_sat = 1'b0;
    end
  end

  // Final sum scaling.
  logic signed [SUM_W-1:0]  fx_adj, fy_adj;
  logic signed [SUM_W-17:0] fx_q, fy_q;
  logic signed [COORD_W-1:0] fx_val, fy_val;
  logic fx_sat, fy_sat;

  always_comb begin
    fx_adj = sx[SUM_W-1] ? sx + SUM_W'(65535) : sx;
    fy_adj = sy[SUM_W-1] ? sy + SUM_W'(65535) : sy;
    fx_q = fx_adj[SUM_W-1:16];
    fy_q = fy_adj[SUM_W-1:16];
    fx_sat = 1'b1;
    fy_sat = 1'b1;
    if (fx_q > (SUM_W-16)'(32767))       fx_val = 16'sh7fff;
    else if (fx_q < -(SUM_W-16)'(32768)) fx_val = 16'sh8000;
    else begin
      fx_val = fx_q[COORD_W-1:0];
      fx_sat = 1'b0;
    end
    if (fy_q > (SUM_W-16)'(32767))       fy_val = 16'sh7fff;
    else if (fy_q < -(SUM_W-16)'(32768)) fy_val = 16'sh8000;
    else begin
      fy_val = fy_q[COORD_W-1:0];
      fy_sat = 1'b0;
    end
  end

  // Knot editing helpers.
  logic            at_top, at_ki, seek_hit;
  logic            up_scan_go, dn_scan_go;
  logic            up_set_wr, up_step_wr, dn_set_wr, dn_step_wr;
  logic [KNOT_W:0] up_raw;
  logic [KNOT_W-1:0] up_nb, up_max, dn_nb, dn_zero;
  logic            l1_in;
  logic [KNOT_W-1:0] rstk_val;

  always_comb begin
    at_top   = (hd == HD_W'(NK - 1));
    at_ki    = (32'(hd) == 32'(req.knot_index));
    seek_hit = at_ki;
    up_scan_go = !at_top && (kt.t0 >= kt.t1);
    dn_scan_go = (hd != '0) && (kt.t0 <= kt.tl);
    up_raw  = {1'b0, kt.t0} + ONE_U;
    up_nb   = (up_raw > {1'b0, kt.t1}) ? kt.t1 : up_raw[KNOT_W-1:0];
    up_max  = (up_raw > {1'b0, max_knot}) ? max_knot : up_raw[KNOT_W-1:0];
    dn_nb   = ({1'b0, kt.t0} < {1'b0, kt.tl} + ONE_U) ? kt.tl : KNOT_W'(kt.t0 - ONE_U);
    dn_zero = ({1'b0, kt.t0} < ONE_U) ? '0 : KNOT_W'(kt.t0 - ONE_U);
    up_set_wr  = !at_top || (kt.t0 < max_knot);
    up_step_wr = kt.t0 < kt.t1;
    dn_set_wr  = (hd != '0) || (kt.t0 != '0);
    dn_step_wr = kt.t0 > kt.tl;
    l1_in = ((kt.t0 < u) && (u <= kt.t1)) ||
            ((cnt == '0) && (kt.t0 <= u) && (u <= kt.t1));
    rstk_val = (racc > RACC_W'(65535)) ? 16'hffff : racc[KNOT_W-1:0];
  end

  // Ring control.
  logic                     nb_sh, pt_sh, pt_wr;
  logic signed [COEF_W-1:0] nb_in;

  always_comb begin
    kctl   = '0;
    kwdata = '0;
    nb_sh  = 1'b0;
    nb_in  = nb[0];
    pt_sh  = 1'b0;
    pt_wr  = 1'b0;
    case (state)
      ST_SEEK:     kctl.fwd = !seek_hit;
      ST_ALIGN:    kctl.fwd = (hd != '0);
      ST_KWR: begin
        kctl.wr = 1'b1;
        kwdata  = req.knot_value;
      end
      ST_RSTK: begin
        kctl.fwd = 1'b1;
        kctl.wr  = 1'b1;
        kwdata   = rstk_val;
      end
      ST_PWR: begin
        pt_sh = 1'b1;
        pt_wr = (32'(cnt) == 32'(req.point_index));
      end
      ST_NUP_SCAN: kctl.fwd = up_scan_go;
      ST_NUP_SET: begin
        kctl.wr = up_set_wr;
        kwdata  = at_top ? up_max : up_nb;
      end
      ST_NUP_BACK: kctl.back = 1'b1;
      ST_NUP_STEP: begin
        kctl.wr = up_step_wr;
        kwdata  = up_nb;
      end
      ST_NDN_SCAN: kctl.back = dn_scan_go;
      ST_NDN_SET: begin
        kctl.wr = dn_set_wr;
        kwdata  = (hd != '0) ? dn_nb : dn_zero;
      end
      ST_NDN_FWD:  kctl.fwd = 1'b1;
      ST_NDN_STEP: begin
        kctl.wr = dn_step_wr;
        kwdata  = dn_nb;
      end
      ST_EV_L1: begin
        kctl.fwd = 1'b1;
        nb_sh    = 1'b1;
        nb_in    = l1_in ? Q_ONE : '0;
      end
      ST_EV_M3: begin
        kctl.fwd = 1'b1;
        nb_sh    = 1'b1;
        nb_in    = lvl_val;
      end
      ST_EV_NBROT: nb_sh = (cnt < CNT_W'(NB));
      ST_EV_KAL:   kctl.fwd = (hd != '0);
      ST_EV_S2: begin
        nb_sh = 1'b1;
        pt_sh = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nb_sh) begin
      for (int p = 0; p < NB - 1; p++) nb[p] <= nb[p+1];
      nb[NB-1] <= nb_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NP; p++) begin
        px[p] <= px_reset_val(p, FRAC_BITS);
        py[p] <= py_reset_val(p, FRAC_BITS);
      end
    end else if (pt_sh) begin
      for (int p = 0; p < NP - 1; p++) begin
        px[p] <= px[p+1];
        py[p] <= py[p+1];
      end
      px[NP-1] <= pt_wr ? req.point_x : px[0];
      py[NP-1] <= pt_wr ? req.point_y : py[0];
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      hd           <= '0;
      cnt          <= '0;
      lvl          <= '0;
      sat          <= 1'b0;
      out_valid    <= 1'b0;
      max_knot     <= max_knot_reset_val(FRAC_BITS);
      knot_spacing <= spacing_reset_val(FRAC_BITS);
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MAX_KNOT:     max_knot <= cfg_data;
          CFG_KNOT_SPACING: knot_spacing <= cfg_data[SPACING_W-1:0];
          default: ;
        endcase
      end
      // In the done state the output register is reloaded instead.
      if (out_valid && out_ready && state != ST_DONE) out_valid <= 1'b0;

      if (kctl.fwd) hd <= (hd == HD_W'(NK - 1)) ? '0 : hd + 1'b1;
      else if (kctl.back) hd <= hd - 1'b1;

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            res_x <= '0;
            res_y <= '0;
            sat   <= 1'b0;
            cnt   <= '0;
            racc  <= '0;
            case (in_data.command)
              CMD_WRITE_KNOT, CMD_NUDGE_UP, CMD_NUDGE_DOWN:
                state <= (32'(in_data.knot_index) < NK) ? ST_SEEK : ST_DONE;
              CMD_WRITE_POINT:
                state <= (32'(in_data.point_index) < NP) ? ST_PWR : ST_DONE;
              CMD_EVALUATE:    state <= ST_EV_L1;
              CMD_RESET_KNOTS: state <= ST_RSTK;
              default:         state <= ST_DONE;
            endcase
          end
        end
        ST_SEEK: begin
          if (seek_hit) begin
            case (req.command)
              CMD_WRITE_KNOT: state <= ST_KWR;
              CMD_NUDGE_UP:   state <= ST_NUP_SCAN;
              default:        state <= ST_NDN_SCAN;
            endcase
          end
        end
        ST_KWR:   state <= ST_ALIGN;
        ST_ALIGN: if (hd == '0) state <= ST_DONE;
        ST_PWR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NP - 1)) state <= ST_DONE;
        end
        ST_RSTK: begin
          cnt  <= cnt + 1'b1;
          racc <= racc + RACC_W'(knot_spacing);
          if (cnt == CNT_W'(NK - 1)) state <= ST_DONE;
        end
        ST_NUP_SCAN: if (!up_scan_go) state <= ST_NUP_SET;
        ST_NUP_SET:  state <= at_ki ? ST_ALIGN : ST_NUP_BACK;
        ST_NUP_BACK: state <= ST_NUP_STEP;
        ST_NUP_STEP: state <= at_ki ? ST_ALIGN : ST_NUP_BACK;
        ST_NDN_SCAN: if (!dn_scan_go) state <= ST_NDN_SET;
        ST_NDN_SET:  state <= at_ki ? ST_ALIGN : ST_NDN_FWD;
        ST_NDN_FWD:  state <= ST_NDN_STEP;
        ST_NDN_STEP: state <= at_ki ? ST_ALIGN : ST_NDN_FWD;
        ST_EV_L1: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NB - 1)) begin
            lvl   <= 3'd1;
            state <= ST_EV_KAL;
          end
        end
        ST_EV_C1: begin
          neg <= num_s[KNOT_W] ^ den_s[KNOT_W];
          if (span_zero) begin
            c1    <= span_hit ? Q_ONE : '0;
            state <= ST_EV_C2;
          end else begin
            state <= ST_EV_D1;
          end
        end
        ST_EV_D1: begin
          if (div_done) begin
            c1    <= coef_q;
            sat   <= sat | coef_sat;
            state <= ST_EV_C2;
          end
        end
        ST_EV_C2: begin
          neg <= num_s[KNOT_W] ^ den_s[KNOT_W];
          if (span_zero) begin
            c2    <= span_hit ? Q_ONE : '0;
            state <= ST_EV_M1;
          end else begin
            state <= ST_EV_D2;
          end
        end
        ST_EV_D2: begin
          if (div_done) begin
            c2    <= coef_q;
            sat   <= sat | coef_sat;
            state <= ST_EV_M1;
          end
        end
        ST_EV_M1: begin
          prod  <= c1 * nb[0];
          state <= ST_EV_M2;
        end
        ST_EV_M2: begin
          acc   <= prod;
          prod  <= c2 * nb[1];
          state <= ST_EV_M3;
        end
        ST_EV_M3: begin
          sat <= sat | lvl_sat;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NK - 1) - CNT_W'(lvl)) state <= ST_EV_NBROT;
          else state <= ST_EV_C1;
        end
        ST_EV_NBROT: begin
          // Entries above this level's last term rotate through unchanged.
          if (cnt < CNT_W'(NB)) cnt <= cnt + 1'b1;
          else state <= ST_EV_KAL;
        end
        ST_EV_KAL: begin
          if (hd == '0) begin
            cnt <= '0;
            if (32'(lvl) == ORDER) begin
              sx    <= '0;
              sy    <= '0;
              state <= ST_EV_S1;
            end else begin
              lvl   <= lvl + 1'b1;
              state <= ST_EV_C1;
            end
          end
        end
        ST_EV_S1: begin
          xprod <= nb[0] * px[0];
          yprod <= nb[0] * py[0];
          state <= ST_EV_S2;
        end
        ST_EV_S2: begin
          sx  <= sx + SUM_W'(xprod);
          sy  <= sy + SUM_W'(yprod);
          cnt <= cnt + 1'b1;
          state <= (cnt == CNT_W'(NP - 1)) ? ST_EV_FIN : ST_EV_S1;
        end
        ST_EV_FIN: begin
          res_x <= fx_val;
          res_y <= fy_val;
          sat   <= sat | fx_sat | fy_sat;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.curve_x <= res_x;
            out_data.curve_y <= res_y;
            out_data.status  <= sat;
            out_valid        <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_idle_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (hd == '0))
    else $error("knot ring not aligned while idle");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_EV_D1 || state == ST_EV_D2))
    else $error("divider finished outside a coefficient wait");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while busy");

endmodule
